[hdl/romaji_word_tokenizer_top_macros.svh]
// Assertion macros for the romaji word tokenizer checker
`ifndef ROMAJI_WORD_TOKENIZER_TOP_MACROS_SVH
`define ROMAJI_WORD_TOKENIZER_TOP_MACROS_SVH

// Clocked assertion with reset disable; expects clk_i and rst_ni in scope
`define RWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same, with the antecedent written separately as an overlapping implication
`define RWT_ASSERT_IMP(lbl, ante, cons, msg) \
  `RWT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[hdl/rwt_pkg.sv]
// Shared types, token codes and reserved-word table for the romaji tokenizer
`timescale 1ns / 1ps

package rwt_pkg;

  localparam int unsigned POS_LIMIT_DEF = 16;
  localparam int unsigned NUM_RES       = 19;
  localparam int unsigned KW_MAX_LEN    = 12;
  localparam int unsigned KW_BITS       = KW_MAX_LEN * 8;
  localparam int unsigned EOFM_IDX      = 18;

  typedef enum logic [3:0] {
    TOK_WORD1       = 4'd0,
    TOK_WORD2       = 4'd1,
    TOK_VERB        = 4'd2,
    TOK_VERBNEG     = 4'd3,
    TOK_VERBPAST    = 4'd4,
    TOK_VERBPASTNEG = 4'd5,
    TOK_IS          = 4'd6,
    TOK_WAS         = 4'd7,
    TOK_OBJECT      = 4'd8,
    TOK_SUBJECT     = 4'd9,
    TOK_DESTINATION = 4'd10,
    TOK_PRONOUN     = 4'd11,
    TOK_CONNECTOR   = 4'd12,
    TOK_PERIOD      = 4'd13,
    TOK_ERROR       = 4'd14,
    TOK_EOFM        = 4'd15
  } token_e;

  // Words are right-justified: first char sits in the highest used byte
  localparam logic [KW_BITS-1:0] KW_TEXT [NUM_RES] = '{
    "masu", "masen", "mashita", "masendeshita", "desu", "deshita",
    "o", "wa", "ni", "watashi", "anata", "kare", "kanojo", "sore",
    "mata", "soshite", "shikashi", "dakara", "eofm"
  };

  localparam logic [3:0] KW_LEN [NUM_RES] = '{
    4'd4, 4'd5, 4'd7, 4'd12, 4'd4, 4'd7, 4'd1, 4'd2, 4'd2, 4'd7,
    4'd5, 4'd4, 4'd6, 4'd4, 4'd4, 4'd7, 4'd8, 4'd6, 4'd4
  };

  localparam token_e KW_TOK [NUM_RES] = '{
    TOK_VERB, TOK_VERBNEG, TOK_VERBPAST, TOK_VERBPASTNEG, TOK_IS, TOK_WAS,
    TOK_OBJECT, TOK_SUBJECT, TOK_DESTINATION, TOK_PRONOUN, TOK_PRONOUN,
    TOK_PRONOUN, TOK_PRONOUN, TOK_PRONOUN, TOK_CONNECTOR, TOK_CONNECTOR,
    TOK_CONNECTOR, TOK_CONNECTOR, TOK_EOFM
  };

  // Word status after the current character, lexer to token stage
  typedef struct packed {
    logic [NUM_RES-1:0] hit;        // still matching and full length reached
    logic               syl_ok;     // recognizer ends on a vowel or final n
    logic               dot_first;  // word opened with '.'
    logic               upper_last; // current char is 'I' or 'E'
  } word_stat_t;

endpackage

[hdl/rwt_lexer.sv]
// Per-word state: syllable recognizer, reserved-word mask, position counter
`timescale 1ns / 1ps

module rwt_lexer #(
  parameter int unsigned PosLimit = rwt_pkg::POS_LIMIT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic [7:0]          ch_i,
  input  logic                word_end_i,
  output rwt_pkg::word_stat_t stat_o
);
  import rwt_pkg::*;

  localparam int unsigned PosW = $clog2(PosLimit + 1);

  typedef enum logic [3:0] {
    ST_START  = 4'd0,
    ST_CONS   = 4'd2,
    ST_T      = 4'd3,
    ST_S_MID  = 4'd4,
    ST_S      = 4'd5,
    ST_C      = 4'd6,
    ST_GLIDE  = 4'd8,
    ST_VOWEL  = 4'd9,
    ST_N      = 4'd10,
    ST_REJECT = 4'd11
  } dfa_e;

  dfa_e               dfa_q, dfa_d;
  logic               first_q;
  logic               dot_q, dot_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [NUM_RES-1:0] mask_q, mask_d;

  logic is_vowel, is_dwzyj, is_bghkmpr;

  assign is_vowel = (ch_i == "a") || (ch_i == "i") || (ch_i == "u") ||
                    (ch_i == "e") || (ch_i == "o") || (ch_i == "I") ||
                    (ch_i == "E");
  assign is_dwzyj = (ch_i == "d") || (ch_i == "w") || (ch_i == "z") ||
                    (ch_i == "y") || (ch_i == "j");
  assign is_bghkmpr = (ch_i == "b") || (ch_i == "g") || (ch_i == "h") ||
                      (ch_i == "k") || (ch_i == "m") || (ch_i == "p") ||
                      (ch_i == "r");

  always_comb begin
    dfa_d = ST_REJECT;
    unique case (dfa_q)
      ST_START, ST_N: begin
        if (is_vowel)                         dfa_d = ST_VOWEL;
        else if (ch_i == "c")                 dfa_d = ST_C;
        else if (ch_i == "s")                 dfa_d = ST_S;
        else if (ch_i == "t")                 dfa_d = ST_T;
        else if (is_dwzyj)                    dfa_d = ST_GLIDE;
        else if (is_bghkmpr || ch_i == "n")   dfa_d = ST_CONS;
      end
      ST_CONS: begin
        if (is_vowel)            dfa_d = ST_VOWEL;
        else if (ch_i == "y")    dfa_d = ST_GLIDE;
      end
      ST_T: begin
        if (is_vowel)            dfa_d = ST_VOWEL;
        else if (ch_i == "s")    dfa_d = ST_GLIDE;
      end
      ST_S_MID, ST_S: begin
        if (is_vowel)            dfa_d = ST_VOWEL;
        else if (ch_i == "h")    dfa_d = ST_GLIDE;
      end
      ST_C: begin
        if (ch_i == "h")         dfa_d = ST_GLIDE;
      end
      ST_GLIDE: begin
        if (is_vowel)            dfa_d = ST_VOWEL;
      end
      ST_VOWEL: begin
        if (is_vowel)            dfa_d = ST_VOWEL;
        else if (ch_i == "n")    dfa_d = ST_N;
        else if (is_bghkmpr)     dfa_d = ST_CONS;
        else if (is_dwzyj)       dfa_d = ST_GLIDE;
        else if (ch_i == "t")    dfa_d = ST_T;
        else if (ch_i == "s")    dfa_d = ST_S_MID;
        else if (ch_i == "c")    dfa_d = ST_C;
      end
      default: dfa_d = ST_REJECT;
    endcase
  end

  // Reserved-word compare at the current position, one lane per word
  always_comb begin
    logic [3:0]         sel;
    logic [KW_BITS-1:0] shifted;
    for (int i = 0; i < NUM_RES; i++) begin
      sel       = KW_LEN[i] - 4'(pos_q) - 4'd1;
      shifted   = KW_TEXT[i] >> {sel, 3'b000};
      mask_d[i] = mask_q[i] && (pos_q < PosW'(KW_LEN[i])) && (shifted[7:0] == ch_i);
    end
  end

  // Saturating count of characters seen, including this one
  assign pos_d = (pos_q == PosW'(PosLimit)) ? pos_q : pos_q + PosW'(1);
  assign dot_d = first_q ? (ch_i == ".") : dot_q;

  always_comb begin
    for (int i = 0; i < NUM_RES; i++) begin
      stat_o.hit[i] = mask_d[i] && (pos_d == PosW'(KW_LEN[i]));
    end
    stat_o.syl_ok     = (dfa_d == ST_VOWEL) || (dfa_d == ST_N);
    stat_o.dot_first  = dot_d;
    stat_o.upper_last = (ch_i == "I") || (ch_i == "E");
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dfa_q   <= ST_START;
      first_q <= 1'b1;
      dot_q   <= 1'b0;
      pos_q   <= '0;
      mask_q  <= '1;
    end else if (acc_i) begin
      if (word_end_i) begin
        dfa_q   <= ST_START;
        first_q <= 1'b1;
        dot_q   <= 1'b0;
        pos_q   <= '0;
        mask_q  <= '1;
      end else begin
        dfa_q   <= dfa_d;
        first_q <= 1'b0;
        dot_q   <= dot_d;
        pos_q   <= pos_d;
        mask_q  <= mask_d;
      end
    end
  end

endmodule

[hdl/rwt_token.sv]
// Token classification at word end and the output register
`timescale 1ns / 1ps

module rwt_token (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_i,
  input  rwt_pkg::word_stat_t stat_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          token_type_o
);
  import rwt_pkg::*;

  token_e tok_d, tok_q;
  logic   valid_q;

  always_comb begin
    token_e kw_tok;
    kw_tok = stat_i.upper_last ? TOK_WORD2 : TOK_WORD1;
    // Lowest index wins among the reserved words
    for (int i = NUM_RES - 1; i >= 0; i--) begin
      if (stat_i.hit[i]) kw_tok = KW_TOK[i];
    end
    priority if (stat_i.hit[EOFM_IDX]) tok_d = TOK_EOFM;
    else if (stat_i.dot_first)         tok_d = TOK_PERIOD;
    else if (!stat_i.syl_ok)           tok_d = TOK_ERROR;
    else                               tok_d = kw_tok;
  end

  assign space_o      = !valid_q || out_ready_i;
  assign out_valid_o  = valid_q;
  assign token_type_o = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= TOK_WORD1;
    end else if (req_i) begin
      valid_q <= 1'b1;
      tok_q   <= tok_d;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

[hdl/romaji_word_tokenizer_top.sv]
// Romaji word tokenizer top level
//
// Takes one character per request; word_end_i flags the last character of
// a word, and that request produces one token. The syllable recognizer
// and all 19 reserved-word compares run in parallel against the per-word
// registers, and the token lands in the output register in the cycle
// after the final character. A new character is taken every cycle as
// long as the output register is empty or being drained, so throughput
// is one character per clock.
`timescale 1ns / 1ps

module romaji_word_tokenizer_top #(
  parameter int unsigned PosLimit = rwt_pkg::POS_LIMIT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       word_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] token_type_o
);
  import rwt_pkg::*;

  logic       acc;
  word_stat_t stat;

  assign acc = in_valid_i && in_ready_o;

  rwt_lexer #(
    .PosLimit(PosLimit)
  ) u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .ch_i       (ch_i),
    .word_end_i (word_end_i),
    .stat_o     (stat)
  );

  rwt_token u_token (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (acc && word_end_i),
    .stat_i       (stat),
    .space_o      (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .token_type_o (token_type_o)
  );

endmodule

[hdl/rwt_checker.sv]
// Port-level checks for the romaji word tokenizer, bound to the top level
`timescale 1ns / 1ps
`include "romaji_word_tokenizer_top_macros.svh"

module rwt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] ch_i,
  input logic       word_end_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [3:0] token_type_o
);
  import rwt_pkg::*;

  logic word_acc;
  logic bad_end;

  assign word_acc = in_valid_i && in_ready_o && word_end_i;
  // Control byte, zero or space as last char: no transition, so reject unless '.'-led
  assign bad_end  = word_acc && (ch_i < 8'h21);

  `RWT_ASSERT_IMP(a_ready_only_on_full, !in_ready_o, out_valid_o && !out_ready_i, "input stalled without a pending token")
  `RWT_ASSERT_IMP(a_token_from_word_end, $rose(out_valid_o), $past(word_acc), "token appeared without a word end")
  `RWT_ASSERT_IMP(a_word_end_gives_token, word_acc, ##1 out_valid_o, "word end produced no token")
  `RWT_ASSERT_IMP(a_bad_char_rejects, bad_end, ##1 (token_type_o == TOK_ERROR || token_type_o == TOK_PERIOD), "word ending in a control byte not rejected")
  `RWT_ASSERT_IMP(a_out_hold, out_valid_o && !out_ready_i, ##1 (out_valid_o && $stable(token_type_o)), "stalled token changed")

endmodule

bind romaji_word_tokenizer_top rwt_checker u_rwt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .ch_i         (ch_i),
  .word_end_i   (word_end_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .token_type_o (token_type_o)
);
